// ===== src/gld_pkg.sv =====
`timescale 1ns / 1ps
package gld_pkg;
  localparam int DICT_CODES_DEF      = 4096;
  localparam int MAX_CODE_WIDTH_DEF  = 12;
  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam logic [1:0] ACT_PAL   = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_PULL  = 2'd2;
  localparam logic [1:0] ACT_START = 2'd3;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_PIXEL  = 3'd1;
  localparam logic [2:0] ST_NEED   = 3'd2;
  localparam logic [2:0] ST_ENDED  = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;

  // one classified command between front and back
  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  idx;
    logic [14:0] rgb;
    logic [7:0]  data;
  } cmd_t;

  function automatic logic [3:0] eff_mcs(input logic [3:0] m);
    if (m < 4'd2) return 4'd2;
    if (m > 4'd8) return 4'd8;
    return m;
  endfunction
endpackage

// ===== src/gld_ram.sv =====
`timescale 1ns / 1ps
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/gld_front.sv =====
`timescale 1ns / 1ps
module gld_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_palette_index,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_data_byte,
  output logic               q_valid,
  input  logic               q_ready,
  output gld_pkg::cmd_t      q_cmd
);
  import gld_pkg::*;
  // two-entry queue
  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic       push, pop;

  always_comb begin
    c.act  = in_action;
    c.idx  = in_palette_index;
    c.rgb  = {in_red[7:3], in_green[7:3], in_blue[7:3]};
    c.data = in_data_byte;
  end
  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = buf_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2) else $error("full queue lost entry");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop) else $error("pop from empty queue");
`endif
endmodule

// ===== src/gld_back.sv =====
`timescale 1ns / 1ps
module gld_back #(
  parameter int DICT_CODES      = gld_pkg::DICT_CODES_DEF,
  parameter int MAX_CODE_WIDTH  = gld_pkg::MAX_CODE_WIDTH_DEF,
  parameter int PALETTE_ENTRIES = gld_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [3:0]    mcs,
  input  logic          q_valid,
  output logic          q_ready,
  input  gld_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [7:0]    out_color_index,
  output logic [14:0]   out_pixel_rgb555
);
  import gld_pkg::*;
  localparam int DW = $clog2(DICT_CODES);
  localparam int PW = $clog2(PALETTE_ENTRIES);
  localparam logic [12:0] DLIM  = 13'(DICT_CODES);
  localparam logic [12:0] GUARD = 13'(DICT_CODES - 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_BIT = 4'd1, S_CODE = 4'd2, S_WALK = 4'd3,
    S_WRD = 4'd4, S_ROOT = 4'd5, S_POP = 4'd6, S_POPW = 4'd7, S_PAL = 4'd8,
    S_PALW = 4'd9;

  // kind of expansion in progress
  localparam logic [1:0] M_LIT = 2'd0, M_KNOWN = 2'd1, M_KWK = 2'd2;

  logic [3:0]  st_r, st_nxt;
  logic [12:0] sc_r, sc_nxt;
  logic [7:0]  bb_r, bb_nxt;
  logic [3:0]  bl_r, bl_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [3:0]  cw_r, cw_nxt;
  logic [12:0] nf_r, nf_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [7:0]  pf_r, pf_nxt;
  logic        ac_r, ac_nxt;
  logic        ie_r, ie_nxt;
  logic [11:0] c_r, c_nxt;     // chain pointer
  logic [11:0] x_r, x_nxt;     // code being expanded
  logic [1:0]  mode_r, mode_nxt; // after clear, known code or kwkwk
  logic [7:0]  col_r, col_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  os_r, os_nxt;
  logic [14:0] orgb_r, orgb_nxt;

  logic          dict_we;
  logic [DW-1:0] dict_wa, dict_ra;
  logic [11:0]   dict_wpre, pre_rd;
  logic [7:0]    dict_wsuf, suf_rd;
  logic          stk_we;
  logic [DW-1:0] stk_wa, stk_ra;
  logic [7:0]    stk_wd, stk_rd;
  logic          pal_we;
  logic [PW-1:0] pal_wa, pal_ra;
  logic [14:0]   pal_rd;

  gld_ram #(.WIDTH(12), .DEPTH(DICT_CODES)) u_pre (.clk(clk), .we(dict_we),
    .waddr(dict_wa), .wdata(dict_wpre), .raddr(dict_ra), .rdata(pre_rd));
  gld_ram #(.WIDTH(8), .DEPTH(DICT_CODES)) u_suf (.clk(clk), .we(dict_we),
    .waddr(dict_wa), .wdata(dict_wsuf), .raddr(dict_ra), .rdata(suf_rd));
  gld_ram #(.WIDTH(8), .DEPTH(DICT_CODES)) u_stk (.clk(clk), .we(stk_we),
    .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));
  gld_ram #(.WIDTH(15), .DEPTH(PALETTE_ENTRIES)) u_pal (.clk(clk), .we(pal_we),
    .waddr(pal_wa), .wdata(q_cmd.rgb), .raddr(pal_ra), .rdata(pal_rd));

  logic [3:0]  em;
  logic [12:0] clr;
  logic [11:0] xa;
  logic [12:0] nf_inc;

  always_comb begin
    em  = eff_mcs(mcs);
    clr = 13'd1 << em;
    xa  = acc_r | (12'(bb_r[0]) << bc_r);
    nf_inc = nf_r + 13'd1;

    st_nxt = st_r; sc_nxt = sc_r; bb_nxt = bb_r; bl_nxt = bl_r; acc_nxt = acc_r;
    bc_nxt = bc_r; cw_nxt = cw_r; nf_nxt = nf_r; pc_nxt = pc_r; pf_nxt = pf_r;
    ac_nxt = ac_r; ie_nxt = ie_r; c_nxt = c_r; x_nxt = x_r; mode_nxt = mode_r;
    col_nxt = col_r; ov_nxt = ov_r; os_nxt = os_r; orgb_nxt = orgb_r;
    q_ready = 1'b0;
    dict_we = 1'b0; dict_wa = nf_r[DW-1:0]; dict_wpre = pc_r; dict_wsuf = pf_r;
    dict_ra = c_r[DW-1:0];
    stk_we = 1'b0; stk_wa = sc_r[DW-1:0]; stk_wd = suf_rd;
    stk_ra = DW'(sc_r - 13'd1);
    pal_we = 1'b0; pal_wa = q_cmd.idx[PW-1:0]; pal_ra = col_r[PW-1:0];

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (st_r)
      S_IDLE: if (!ov_r || out_ready) begin
        q_ready = 1'b1;
        if (q_valid) begin
          os_nxt = ST_DONE; col_nxt = 8'd0; orgb_nxt = 15'd0;
          case (q_cmd.act)
            ACT_PAL: begin
              pal_we = ({8'd0, q_cmd.idx} < 16'(PALETTE_ENTRIES));
              ov_nxt = 1'b1;
            end
            ACT_PUSH: begin
              if (ie_r) os_nxt = ST_ENDED;
              else if (bl_r != 4'd0) os_nxt = ST_REJECT;
              else begin bb_nxt = q_cmd.data; bl_nxt = 4'd8; end
              ov_nxt = 1'b1;
            end
            ACT_PULL: st_nxt = (sc_r != 13'd0) ? S_POP : S_BIT;
            default: begin
              sc_nxt = 13'd0; bb_nxt = 8'd0; bl_nxt = 4'd0; acc_nxt = 12'd0;
              bc_nxt = 4'd0; ie_nxt = 1'b0; cw_nxt = em + 4'd1; nf_nxt = clr + 13'd2;
              pc_nxt = 12'd0; pf_nxt = 8'd0; ac_nxt = 1'b1;
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      S_BIT: begin
        // shift one bit per cycle into the code accumulator
        if (ie_r) begin os_nxt = ST_ENDED; ov_nxt = 1'b1; st_nxt = S_IDLE; end
        else if (bl_r == 4'd0) begin os_nxt = ST_NEED; ov_nxt = 1'b1; st_nxt = S_IDLE; end
        else begin
          bb_nxt = bb_r >> 1; bl_nxt = bl_r - 4'd1;
          if (bc_r + 4'd1 >= cw_r) begin
            acc_nxt = 12'd0; bc_nxt = 4'd0; x_nxt = xa; st_nxt = S_CODE;
          end else begin
            acc_nxt = xa; bc_nxt = bc_r + 4'd1;
          end
        end
      end
      S_CODE: begin
        st_nxt = S_BIT;
        if ({1'b0, x_r} == clr) begin
          cw_nxt = em + 4'd1; nf_nxt = clr + 13'd2; pc_nxt = 12'd0; pf_nxt = 8'd0;
          ac_nxt = 1'b1;
        end else if ({1'b0, x_r} == clr + 13'd1) begin
          ie_nxt = 1'b1; bl_nxt = 4'd0; bb_nxt = 8'd0;
        end else if (ac_r) begin
          if ({1'b0, x_r} < clr) begin
            mode_nxt = M_LIT; sc_nxt = 13'd0; c_nxt = x_r; st_nxt = S_WALK;
          end
        end else if ({1'b0, x_r} < nf_r) begin
          mode_nxt = M_KNOWN; sc_nxt = 13'd0; c_nxt = x_r; st_nxt = S_WALK;
        end else if ({1'b0, x_r} == nf_r && nf_r < DLIM) begin
          // code not yet in the table: add entry first, then expand
          mode_nxt = M_KWK; sc_nxt = 13'd0; c_nxt = x_r; st_nxt = S_WALK;
          dict_we = 1'b1;
          nf_nxt = nf_inc;
          if (cw_r < 4'(MAX_CODE_WIDTH) && nf_inc == (13'd1 << cw_r)) cw_nxt = cw_r + 4'd1;
        end
      end
      S_WALK: begin
        if ({1'b0, c_r} >= clr && sc_r < GUARD) begin
          if ({1'b0, c_r} >= DLIM) begin c_nxt = 12'd0; st_nxt = S_ROOT; end
          else st_nxt = S_WRD; // dictionary read issued
        end else st_nxt = S_ROOT;
      end
      S_WRD: begin
        stk_we = 1'b1; sc_nxt = sc_r + 13'd1; c_nxt = pre_rd; st_nxt = S_WALK;
      end
      S_ROOT: begin
        stk_we = 1'b1; stk_wd = c_r[7:0]; sc_nxt = sc_r + 13'd1;
        pc_nxt = x_r;
        if (mode_r == M_LIT) begin
          pf_nxt = x_r[7:0]; ac_nxt = 1'b0;
        end else if (mode_r == M_KNOWN) begin
          pf_nxt = c_r[7:0];
          if (nf_r < DLIM) begin
            dict_we = 1'b1; dict_wsuf = c_r[7:0];
            nf_nxt = nf_inc;
            if (cw_r < 4'(MAX_CODE_WIDTH) && nf_inc == (13'd1 << cw_r))
              cw_nxt = cw_r + 4'd1;
          end
        end
        st_nxt = S_POP;
      end
      S_POP: begin
        // stack read issued at top, wait for data
        sc_nxt = sc_r - 13'd1; st_nxt = S_POPW;
      end
      S_POPW: begin col_nxt = stk_rd; st_nxt = S_PAL; end
      S_PAL: st_nxt = S_PALW;
      S_PALW: begin
        orgb_nxt = ({5'd0, col_r} < 13'(PALETTE_ENTRIES)) ? pal_rd : 15'd0;
        os_nxt = ST_PIXEL; ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt; x_r <= x_nxt; mode_r <= mode_nxt; col_r <= col_nxt;
    os_r <= os_nxt; orgb_r <= orgb_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; sc_r <= 13'd0; bb_r <= 8'd0; bl_r <= 4'd0; acc_r <= 12'd0;
      bc_r <= 4'd0; cw_r <= 4'd9; nf_r <= 13'd258; pc_r <= 12'd0; pf_r <= 8'd0;
      ac_r <= 1'b1; ie_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sc_r <= sc_nxt; bb_r <= bb_nxt; bl_r <= bl_nxt; acc_r <= acc_nxt;
      bc_r <= bc_nxt; cw_r <= cw_nxt; nf_r <= nf_nxt; pc_r <= pc_nxt; pf_r <= pf_nxt;
      ac_r <= ac_nxt; ie_r <= ie_nxt; ov_r <= ov_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_color_index  = col_r & {8{os_r == ST_PIXEL}};
  assign out_pixel_rgb555 = orgb_r;

`ifndef SYNTHESIS
  a_cw: assert property (@(posedge clk) disable iff (!rst_n)
    cw_r <= 4'(MAX_CODE_WIDTH)) else $error("code width too large");
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= DLIM) else $error("next free code past dictionary");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(os_r)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !q_ready) else $error("queue popped while busy");
`endif
endmodule

// ===== src/gif_lzw_decoder.sv =====
`timescale 1ns / 1ps
// GIF LZW decoder with RGB555 palette.
// Input channel (in_valid/in_ready): one beat per command: in_action selects
// palette write, data byte push, pixel pull or image start. Every beat gives
// exactly one result beat on out_valid/out_ready: out_status, out_color_index
// and out_pixel_rgb555 (index and color are zero unless status is pixel).
// Config channel (cfg_valid/cfg_ready): writes min_code_size; write only idle.
// A two-entry command queue decouples acceptance from execution.
// Palette write, push and start are carried out when taken from the queue.
// A pull served from the pixel stack pops it, reads the palette and registers
// the pixel; a pull that must fetch a code first shifts in its bits, classifies
// it, reads the prefix/suffix RAM per dictionary chain link and stacks the root.
// Throughput: palette writes, pushes and starts run one per cycle while the
// receiver is ready; pulls are not overlapped (stack, then palette RAM read).
// Reset: synchronous, active low; clears control state; min_code_size is 8.
// Palette and dictionary contents are undefined until written.
// A stalled receiver holds the result register; the queue then fills and
// in_ready drops.
module gif_lzw_decoder #(
  parameter int DICT_CODES      = gld_pkg::DICT_CODES_DEF,
  parameter int MAX_CODE_WIDTH  = gld_pkg::MAX_CODE_WIDTH_DEF,
  parameter int PALETTE_ENTRIES = gld_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_min_code_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_palette_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_color_index,
  output logic [14:0] out_pixel_rgb555
);
  import gld_pkg::*;
  logic [3:0] mcs_r;
  logic       q_valid, q_ready;
  cmd_t       q_cmd;

  // config register; always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mcs_r <= 4'd8;
    else if (cfg_valid) mcs_r <= cfg_min_code_size;
  end

  gld_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(in_valid),
    .in_ready(in_ready), .in_action(in_action), .in_palette_index(in_palette_index),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_data_byte(in_data_byte), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

  gld_back #(.DICT_CODES(DICT_CODES), .MAX_CODE_WIDTH(MAX_CODE_WIDTH),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (.clk(clk), .rst_n(rst_n),
    .mcs(mcs_r), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_color_index(out_color_index), .out_pixel_rgb555(out_pixel_rgb555));
endmodule
